### rtl/core/dmxswr_pkg.sv
package dmxswr_pkg;

	localparam int unsigned CHANNELS_DEF = 4;
	localparam int unsigned CHANNELS_MAX = 512;

	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned SLOT_W  = 10;
	localparam int unsigned INDEX_W = 9;
	localparam int unsigned BYTE_W  = 8;

	localparam logic [SLOT_W-1:0] START_ADDRESS_RST = 10'd1;

	typedef enum logic [0:0] {
		REG_START_ADDRESS = 1'b0
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_BREAK   = 4'b0010,
		ST_ARMED   = 4'b0100,
		ST_CAPTURE = 4'b1000
	} rx_state_t;

endpackage

### rtl/core/dmx512_slot_window_receiver_top.sv
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// input    | in_valid / in_stall       | rx_byte, framing_error
// output   | out_valid / out_stall     | channel_index, channel_value, frame_complete
// config   | APB psel/penable/pready   | paddr, pwdata, prdata (start_address)
//
// One transaction per cycle while in_stall is low; a result is loaded into the
// output register when its input is accepted. The byte decode sits between the state
// registers and that single output register. in_stall is high only while a
// result is held by out_stall. Reset: idle, slot counter zero, start_address 1.
module dmx512_slot_window_receiver_top import dmxswr_pkg::*; #(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [BYTE_W-1:0]  rx_byte,
	input  logic               framing_error,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [INDEX_W-1:0] channel_index,
	output logic [BYTE_W-1:0]  channel_value,
	output logic               frame_complete,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	localparam logic [SLOT_W:0] ChanCnt = (SLOT_W+1)'(CHANNELS);

	logic [SLOT_W-1:0]  start_address_q;
	rx_state_t          state_q, state_d;
	logic [SLOT_W-1:0]  slot_cnt_q, slot_cnt_d;
	logic               out_valid_q;
	logic [INDEX_W-1:0] channel_index_q;
	logic [BYTE_W-1:0]  channel_value_q;
	logic               frame_complete_q;

	logic               accept;
	logic               emit;
	logic [INDEX_W-1:0] emit_idx;
	logic               emit_last;
	logic [SLOT_W-1:0]  cnt_dec;
	logic [SLOT_W:0]    cnt_inc;
	reg_idx_t           reg_sel;
	logic               reg_hit;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1]);
	assign reg_hit = (reg_sel == REG_START_ADDRESS);

	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = {{(DATA_W-SLOT_W){1'b0}}, start_address_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_address_q <= START_ADDRESS_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			start_address_q <= pwdata[SLOT_W-1:0];
		end
	end

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign cnt_dec  = slot_cnt_q - 1'b1;
	assign cnt_inc  = {1'b0, slot_cnt_q} + 1'b1;

	always_comb begin
		state_d   = state_q;
		slot_cnt_d = slot_cnt_q;
		emit      = 1'b0;
		emit_idx  = '0;
		emit_last = 1'b0;
		if (framing_error) begin
			state_d    = ST_BREAK;
			slot_cnt_d = start_address_q;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					state_d = ST_IDLE;
				end
				ST_BREAK: begin
					state_d = (rx_byte == '0) ? ST_ARMED : ST_IDLE;
				end
				ST_ARMED: begin
					slot_cnt_d = cnt_dec;
					if (cnt_dec == '0) begin
						emit = 1'b1;
						if (CHANNELS <= 1) begin
							emit_last = 1'b1;
							state_d   = ST_IDLE;
						end else begin
							slot_cnt_d = SLOT_W'(1);
							state_d    = ST_CAPTURE;
						end
					end
				end
				ST_CAPTURE: begin
					emit       = 1'b1;
					emit_idx   = slot_cnt_q[INDEX_W-1:0];
					emit_last  = (cnt_inc >= ChanCnt);
					slot_cnt_d = cnt_inc[SLOT_W-1:0];
					if (emit_last) begin
						state_d = ST_IDLE;
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			slot_cnt_q <= '0;
		end else if (accept) begin
			state_q    <= state_d;
			slot_cnt_q <= slot_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			channel_index_q  <= emit_idx;
			channel_value_q  <= rx_byte;
			frame_complete_q <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign channel_index  = channel_index_q;
	assign channel_value  = channel_value_q;
	assign frame_complete = frame_complete_q;

endmodule

### rtl/core/dmxswr_checker.sv
module dmxswr_checker import dmxswr_pkg::*; #(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               framing_error,
	input logic               out_valid,
	input logic               out_stall,
	input logic [INDEX_W-1:0] channel_index,
	input logic [BYTE_W-1:0]  channel_value,
	input logic               frame_complete
);

	localparam logic [INDEX_W:0] ChanCnt = (INDEX_W+1)'(CHANNELS);

	// held result transaction stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(channel_index)
			&& $stable(channel_value) && $stable(frame_complete))
		else $error("output transaction changed while stalled");

	// input is only back-pressured by a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a held result");

	// a break byte never produces a result
	a_break_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && framing_error |=>
			out_valid == $past(out_valid && out_stall))
		else $error("result produced from a break");

	// index stays within the window, last channel flagged at the window end
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, channel_index} < ChanCnt)
			&& (frame_complete == ({1'b0, channel_index} + 1'b1 == ChanCnt)))
		else $error("channel index outside window");

endmodule

bind dmx512_slot_window_receiver_top dmxswr_checker #(
	.CHANNELS(CHANNELS)
) u_dmxswr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.framing_error(framing_error),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.channel_index(channel_index),
	.channel_value(channel_value),
	.frame_complete(frame_complete)
);
